/* hw/rtl/gregorian_date_unit_assert.svh */
// Assertion macros for the Gregorian date unit.
// Needs a clock named aclk and an active-low reset named aresetn in scope.
`ifndef GREGORIAN_DATE_UNIT_ASSERT_SVH
`define GREGORIAN_DATE_UNIT_ASSERT_SVH

// Same-cycle implication, disabled in reset
`define GDU_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled in reset
`define GDU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/gdu_pkg.sv */
// Shared types, constants and calendar functions of the Gregorian date unit.
// Depends on nothing; imported by gregorian_date_unit.
`default_nettype none

package gdu_pkg;

    // Year arithmetic width (wraps modulo 2^YEAR_BITS), legal from 12 to 32
    localparam int YEAR_BITS  = 16;
    localparam int DAY_W      = 5;
    localparam int MONTH_W    = 4;
    localparam int YEAR_W     = 16;
    localparam int YDAY_W     = 9;
    localparam int RES_W      = 5;   // residue modulo 25
    localparam int SUM_W      = 6;   // partly reduced residue, below 50
    localparam int S_DATA_W   = 32;
    localparam int M_DATA_W   = 72;
    localparam int YEAR_PAD_W = 32;  // year widened to four whole bytes

    localparam logic [YEAR_BITS-1:0] YEAR_TOP = {YEAR_BITS{1'b1}};

    // Month numbers
    localparam logic [MONTH_W-1:0] MON_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MON_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MON_MAR = 4'd3;
    localparam logic [MONTH_W-1:0] MON_APR = 4'd4;
    localparam logic [MONTH_W-1:0] MON_MAY = 4'd5;
    localparam logic [MONTH_W-1:0] MON_JUN = 4'd6;
    localparam logic [MONTH_W-1:0] MON_JUL = 4'd7;
    localparam logic [MONTH_W-1:0] MON_AUG = 4'd8;
    localparam logic [MONTH_W-1:0] MON_SEP = 4'd9;
    localparam logic [MONTH_W-1:0] MON_OCT = 4'd10;
    localparam logic [MONTH_W-1:0] MON_NOV = 4'd11;
    localparam logic [MONTH_W-1:0] MON_DEC = 4'd12;

    localparam logic [DAY_W-1:0] DAY_FIRST = 5'd1;
    localparam logic [DAY_W-1:0] DAYS_LONG = 5'd31;
    localparam logic [DAY_W-1:0] DAYS_SHORT = 5'd30;
    localparam logic [DAY_W-1:0] DAYS_FEB_LEAP = 5'd29;
    localparam logic [DAY_W-1:0] DAYS_FEB = 5'd28;

    localparam logic [SUM_W-1:0] MOD_BASE = 6'd25;

    // Byte residue table: b mod 25 for every byte value
    typedef logic [RES_W-1:0] mod25_table_t [256];

    function automatic mod25_table_t build_mod25();
        mod25_table_t t;
        for (int i = 0; i < 256; i++) begin
            t[i] = RES_W'(i % 25);
        end
        return t;
    endfunction

    localparam mod25_table_t MOD25_LUT = build_mod25();

    // Item context carried down the pipeline
    typedef struct packed {
        logic [DAY_W-1:0]     day;
        logic [MONTH_W-1:0]   month;
        logic [YEAR_BITS-1:0] year;
        logic [YEAR_BITS-1:0] year_inc;
        logic [YEAR_BITS-1:0] year_dec;
        logic [YDAY_W-1:0]    yday_base;   // days before month plus day
        logic                 after_feb;
        logic                 month_ok;
        logic                 year_zero;
        logic                 year_top;
        logic                 year_one;
    } ctx_t;

    // Result of one date
    typedef struct packed {
        logic                 range_edge;
        logic [YEAR_W-1:0]    prev_year;
        logic [MONTH_W-1:0]   prev_month;
        logic [DAY_W-1:0]     prev_day;
        logic [YEAR_W-1:0]    next_year;
        logic [MONTH_W-1:0]   next_month;
        logic [DAY_W-1:0]     next_day;
        logic [YDAY_W-1:0]    year_day;
        logic [DAY_W-1:0]     month_length;
        logic                 date_valid;
    } result_t;

    // Days in a month; zero for a month number outside the calendar
    function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                    input logic leap);
        logic [DAY_W-1:0] n;
        case (m) inside
            MON_JAN, MON_MAR, MON_MAY, MON_JUL, MON_AUG, MON_OCT, MON_DEC: n = DAYS_LONG;
            MON_APR, MON_JUN, MON_SEP, MON_NOV: n = DAYS_SHORT;
            MON_FEB: n = leap ? DAYS_FEB_LEAP : DAYS_FEB;
            default: n = '0;
        endcase
        return n;
    endfunction

    // Days in the year before the first of a month (common year)
    function automatic logic [YDAY_W-1:0] days_before(input logic [MONTH_W-1:0] m);
        logic [YDAY_W-1:0] n;
        unique case (m)
            MON_JAN: n = 9'd0;
            MON_FEB: n = 9'd31;
            MON_MAR: n = 9'd59;
            MON_APR: n = 9'd90;
            MON_MAY: n = 9'd120;
            MON_JUN: n = 9'd151;
            MON_JUL: n = 9'd181;
            MON_AUG: n = 9'd212;
            MON_SEP: n = 9'd243;
            MON_OCT: n = 9'd273;
            MON_NOV: n = 9'd304;
            MON_DEC: n = 9'd334;
            default: n = '0;
        endcase
        return n;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/gregorian_date_unit.sv */
// Gregorian date unit: validity, month length, day of year, next and previous date.
// Depends on gdu_pkg and gregorian_date_unit_assert.svh.
//
// One date enters per beat on the s_ channel and one result leaves per beat on the
// m_ channel; the unit sustains one date per cycle while m_tready is high. Each
// date passes through the three pipeline registers: byte residues of the year modulo
// 25 and the month decode, then the residue sum, then the leap rule and the
// next/previous date into the output register. Back-pressure on m_tready only
// fills bubbles up the pipeline, so nothing is lost or repeated. An invalid date
// (month outside 1..12, year zero, day outside the month) gives date_valid low and
// every other field zero. range_edge marks a following date that wraps to year
// zero or a preceding date that falls to year zero.
`default_nettype none

module gregorian_date_unit (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // day_in[4:0], month_in[8:5], year_in[24:9], zero [31:25]
    input  wire logic [gdu_pkg::S_DATA_W-1:0]  s_tdata,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // date_valid[0], month_length[5:1], year_day[14:6], next_day[19:15],
    // next_month[23:20], next_year[39:24], prev_day[44:40], prev_month[48:45],
    // prev_year[64:49], range_edge[65], zero [71:66]
    output logic [gdu_pkg::M_DATA_W-1:0]       m_tdata
);
    import gdu_pkg::*;

    `include "gregorian_date_unit_assert.svh"

    localparam int RES_BITS = $bits(result_t);

    // Input unpacking
    logic [DAY_W-1:0]      in_day;
    logic [MONTH_W-1:0]    in_month;
    logic [YEAR_BITS-1:0]  in_year;
    logic [YEAR_PAD_W-1:0] in_year_pad;

    assign in_day      = s_tdata[DAY_W-1:0];
    assign in_month    = s_tdata[DAY_W+MONTH_W-1:DAY_W];
    assign in_year     = YEAR_BITS'(s_tdata[DAY_W+MONTH_W+YEAR_W-1:DAY_W+MONTH_W]);
    assign in_year_pad = YEAR_PAD_W'(in_year);

    // Stage handshake: each stage loads when it is empty or its beat moves on
    logic a_valid_reg, b_valid_reg, c_valid_reg;
    logic a_ready, b_ready, c_ready;

    assign c_ready  = !c_valid_reg || m_tready;
    assign b_ready  = !b_valid_reg || c_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign s_tready = a_ready;

    // Stage A: month decode, year neighbours, byte residues modulo 25
    ctx_t              a_ctx_next, a_ctx_reg;
    logic [RES_W-1:0]  a_res_next [4];
    logic [RES_W-1:0]  a_res_reg  [4];

    always_comb begin
        a_ctx_next.day       = in_day;
        a_ctx_next.month     = in_month;
        a_ctx_next.year      = in_year;
        a_ctx_next.year_inc  = in_year + YEAR_BITS'(1);
        a_ctx_next.year_dec  = in_year - YEAR_BITS'(1);
        a_ctx_next.yday_base = days_before(in_month) + YDAY_W'(in_day);
        a_ctx_next.after_feb = (in_month > MON_FEB);
        a_ctx_next.month_ok  = (in_month >= MON_JAN) && (in_month <= MON_DEC);
        a_ctx_next.year_zero = (in_year == '0);
        a_ctx_next.year_top  = (in_year == YEAR_TOP);
        a_ctx_next.year_one  = (in_year == YEAR_BITS'(1));
        for (int i = 0; i < 4; i++) begin
            a_res_next[i] = MOD25_LUT[in_year_pad[8*i +: 8]];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (a_ready) begin
            a_valid_reg <= s_tvalid;
        end
        if (a_ready && s_tvalid) begin
            a_ctx_reg <= a_ctx_next;
            a_res_reg <= a_res_next;
        end
    end

    // Stage B: weight byte residues (256^k mod 25 = 1, 6, 11, 16), reduce below 50
    ctx_t             b_ctx_reg;
    logic [9:0]       b_sum;
    logic [SUM_W-1:0] b_part_next, b_part_reg;

    always_comb begin
        b_sum = 10'(a_res_reg[0]) + 10'(a_res_reg[1]) * 10'd6
              + 10'(a_res_reg[2]) * 10'd11 + 10'(a_res_reg[3]) * 10'd16;
        b_part_next = SUM_W'(MOD25_LUT[b_sum[7:0]]) + SUM_W'(b_sum[9:8]) * SUM_W'(6);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (b_ready) begin
            b_valid_reg <= a_valid_reg;
        end
        if (b_ready && a_valid_reg) begin
            b_ctx_reg  <= a_ctx_reg;
            b_part_reg <= b_part_next;
        end
    end

    // Stage C: leap rule, validity, day of year, next and previous date
    logic [SUM_W-1:0] c_mod25;
    logic             c_leap;
    logic [DAY_W-1:0] c_mlen;
    logic             c_ok;
    result_t          c_res_next, c_res_reg;

    always_comb begin
        c_mod25 = (b_part_reg >= MOD_BASE) ? b_part_reg - MOD_BASE : b_part_reg;
        // divisible by 4 but not 100, or by 400 (16 and 25)
        c_leap  = ((b_ctx_reg.year[1:0] == 2'b00) && (c_mod25 != '0))
               || ((b_ctx_reg.year[3:0] == 4'b0000) && (c_mod25 == '0));
        c_mlen  = month_days(b_ctx_reg.month, c_leap);
        c_ok    = b_ctx_reg.month_ok && !b_ctx_reg.year_zero
               && (b_ctx_reg.day != '0) && (b_ctx_reg.day <= c_mlen);

        c_res_next              = '0;
        c_res_next.date_valid   = 1'b1;
        c_res_next.month_length = c_mlen;
        c_res_next.year_day     = b_ctx_reg.yday_base
                                + YDAY_W'(b_ctx_reg.after_feb && c_leap);

        // following date
        c_res_next.next_month = b_ctx_reg.month;
        c_res_next.next_year  = YEAR_W'(b_ctx_reg.year);
        if (b_ctx_reg.day == c_mlen) begin
            c_res_next.next_day = DAY_FIRST;
            if (b_ctx_reg.month == MON_DEC) begin
                c_res_next.next_month = MON_JAN;
                c_res_next.next_year  = YEAR_W'(b_ctx_reg.year_inc);
                c_res_next.range_edge = b_ctx_reg.year_top;
            end else begin
                c_res_next.next_month = b_ctx_reg.month + MONTH_W'(1);
            end
        end else begin
            c_res_next.next_day = b_ctx_reg.day + DAY_W'(1);
        end

        // preceding date
        c_res_next.prev_month = b_ctx_reg.month;
        c_res_next.prev_year  = YEAR_W'(b_ctx_reg.year);
        if (b_ctx_reg.day == DAY_FIRST) begin
            if (b_ctx_reg.month == MON_JAN) begin
                c_res_next.prev_day   = DAYS_LONG;
                c_res_next.prev_month = MON_DEC;
                c_res_next.prev_year  = YEAR_W'(b_ctx_reg.year_dec);
                if (b_ctx_reg.year_one) begin
                    c_res_next.range_edge = 1'b1;
                end
            end else begin
                c_res_next.prev_month = b_ctx_reg.month - MONTH_W'(1);
                c_res_next.prev_day   = month_days(b_ctx_reg.month - MONTH_W'(1), c_leap);
            end
        end else begin
            c_res_next.prev_day = b_ctx_reg.day - DAY_W'(1);
        end

        // drop everything for a bad date
        if (!c_ok) begin
            c_res_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg <= 1'b0;
        end else if (c_ready) begin
            c_valid_reg <= b_valid_reg;
        end
        if (c_ready && b_valid_reg) begin
            c_res_reg <= c_res_next;
        end
    end

    // Output beat
    assign m_tvalid = c_valid_reg;
    assign m_tdata  = M_DATA_W'(c_res_reg);

    // Checks
    `GDU_ASSERT_NOW(a_invalid_zero, m_tvalid && !c_res_reg.date_valid,
        c_res_reg[RES_BITS-1:1] == '0, "invalid date carries non-zero fields")
    `GDU_ASSERT_NOW(a_valid_shape, m_tvalid && c_res_reg.date_valid,
        (c_res_reg.month_length >= DAYS_FEB) && (c_res_reg.year_day != '0)
        && (c_res_reg.next_month >= MON_JAN) && (c_res_reg.next_month <= MON_DEC),
        "valid result out of calendar range")
    `GDU_ASSERT_NOW(a_edge_valid, m_tvalid && c_res_reg.range_edge,
        c_res_reg.date_valid, "range edge raised on an invalid date")
    `GDU_ASSERT_NEXT(a_stall_hold, c_valid_reg && !m_tready,
        c_valid_reg && $stable(c_res_reg), "output register changed under stall")

endmodule

`default_nettype wire
